// ===== hdl/bsc_pkg.sv =====
// Package for the closed cubic B-spline curve generator.
// Word types, widths, segment selection codes and control/status structs.
// No dependencies.
package bsc_pkg;

	localparam int COORD_BITS = 16;
	// coefficient width: |A| < 8 * 2^(COORD_BITS-1)
	localparam int CW = COORD_BITS + 4;
	// weight width: 3 * j^2 * N <= 10125
	localparam int WW = 14;
	// product width: coefficient times zero-extended weight
	localparam int PW = CW + WW + 1;
	// numerator width: |num| <= 6 * N^3 * 2^(COORD_BITS-1)
	localparam int NW = COORD_BITS + 16;
	// denominator width: 6 * N^3 <= 20250
	localparam int DW = 15;
	localparam int STEP_BITS = 4;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [STEP_BITS-1:0] step_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   is_last_point;
	} in_word_t;

	typedef struct packed {
		coord_t curve_x;
		coord_t curve_y;
		logic   pen_move;
		logic   last_vertex;
	} out_word_t;

	// segment window sources
	localparam logic [1:0] SEL_MAIN  = 2'd0;
	localparam logic [1:0] SEL_TWO   = 2'd1;
	localparam logic [1:0] SEL_THREE = 2'd2;

	typedef struct packed {
		logic       in_take;
		logic       op_wr;
		logic [1:0] op_idx;
		logic       seg_load;
		logic [1:0] sel;
		logic [1:0] seg_k;
		logic       shift;
		logic       vtx_start;
		step_t      j;
		logic       push;
		logic       move;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic  res_ready;
		logic  out_free;
		step_t n_eff;
	} sts_t;

endpackage

// ===== hdl/bsc_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncation toward zero.
// Depends on bsc_pkg. Quotient magnitude is known to fit in COORD_BITS bits.
module bsc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       clear,
	input  logic signed [bsc_pkg::NW-1:0] num,
	input  logic [bsc_pkg::DW-1:0]     den,
	output logic                       done,
	output bsc_pkg::coord_t            quo
);
	import bsc_pkg::*;

	localparam int CNTW = $clog2(COORD_BITS + 1);

	logic [NW-1:0]         mag;
	logic [DW-1:0]         rem_q;
	logic [COORD_BITS-1:0] low_q;
	logic [COORD_BITS-1:0] quo_q;
	logic                  neg_q;
	logic [CNTW-1:0]       cnt_q;
	logic                  done_q;
	logic [DW:0]           trial;
	logic                  fits;

	assign mag   = num[NW-1] ? NW'(-num) : NW'(num);
	assign trial = {rem_q, low_q[COORD_BITS-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(COORD_BITS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1))
				done_q <= 1'b1;
		end else if (clear) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1];
			// high part is below den since the quotient fits
			rem_q <= mag[COORD_BITS+DW-1:COORD_BITS];
			low_q <= mag[COORD_BITS-1:0];
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
			low_q <= {low_q[COORD_BITS-2:0], 1'b0};
			quo_q <= {quo_q[COORD_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? coord_t'(-quo_q) : coord_t'(quo_q);

endmodule

// ===== hdl/bsc_dp.sv =====
// Datapath: point stores, segment coefficients, vertex evaluation pipeline,
// output word register and step register. Depends on bsc_pkg, bsc_div.
module bsc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  bsc_pkg::cmd_t      cmd,
	output bsc_pkg::sts_t      sts,
	input  bsc_pkg::in_word_t  in_word,
	input  logic               cfg_we,
	input  bsc_pkg::step_t     cfg_wdata,
	output logic               out_valid,
	input  logic               out_stall,
	output bsc_pkg::out_word_t out_word
);
	import bsc_pkg::*;

	typedef logic signed [CW-1:0] coef_t;
	typedef logic signed [PW-1:0] prod_t;

	step_t      steps_q;
	step_t      n_eff;
	pt_t        op_q [3];
	pt_t        rc_q [3];
	pt_t        cur_q;
	pt_t        seq [8];
	pt_t        win [4];
	coef_t      cx_q [4];
	coef_t      cy_q [4];
	logic [WW-1:0] w_s1 [4];
	prod_t      px_s2 [4];
	prod_t      py_s2 [4];
	logic signed [NW-1:0] nx_s3, ny_s3;
	logic       v1_q, v2_q, v3_q;
	logic [DW-1:0] den;
	logic       done_x, done_y;
	coord_t     qx, qy;
	out_word_t  out_q;
	logic       out_valid_q;
	logic [7:0] j2, n2;
	logic [11:0] j3, n3;

	assign n_eff = (steps_q == '0) ? step_t'(1) : steps_q;
	assign n2    = {4'd0, n_eff} * {4'd0, n_eff};
	assign n3    = {4'd0, n2} * {8'd0, n_eff};
	assign den   = DW'(3'd6 * {3'd0, n3});
	assign j2    = {4'd0, cmd.j} * {4'd0, cmd.j};
	assign j3    = {4'd0, j2} * {8'd0, cmd.j};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			steps_q <= step_t'(8);
		else if (cfg_we)
			steps_q <= cfg_wdata;
	end

	// point stores
	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			cur_q <= '{x: in_word.point_x, y: in_word.point_y};
			if (cmd.op_wr)
				op_q[cmd.op_idx] <= '{x: in_word.point_x, y: in_word.point_y};
		end
		if (cmd.shift) begin
			rc_q[0] <= rc_q[1];
			rc_q[1] <= rc_q[2];
			rc_q[2] <= cur_q;
		end
	end

	// window of four points for the segment being loaded
	always_comb begin
		for (int i = 0; i < 8; i++)
			seq[i] = cur_q;
		unique case (cmd.sel)
			SEL_MAIN: begin
				seq[0] = rc_q[0];
				seq[1] = rc_q[1];
				seq[2] = rc_q[2];
			end
			SEL_TWO: begin
				for (int i = 0; i < 6; i++)
					seq[i] = op_q[i % 2];
			end
			SEL_THREE: begin
				seq[0] = rc_q[0];
				seq[1] = rc_q[1];
				seq[2] = rc_q[2];
				seq[3] = op_q[0];
				seq[4] = op_q[1];
				seq[5] = op_q[2];
			end
			default: ;
		endcase
		for (int i = 0; i < 4; i++)
			win[i] = seq[3'(cmd.seg_k) + 3'(i)];
	end

	function automatic coef_t coef(input int sel, input coord_t a, input coord_t b,
	                               input coord_t c, input coord_t d);
		coef_t ea, eb, ec, ed, r;
		ea = CW'(a);
		eb = CW'(b);
		ec = CW'(c);
		ed = CW'(d);
		unique case (sel)
			0:       r = ed - ea + ((eb - ec) <<< 1) + (eb - ec);
			1:       r = ea - (eb <<< 1) + ec;
			2:       r = ec - ea;
			default: r = ea + (eb <<< 2) + ec;
		endcase
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.seg_load)
			for (int i = 0; i < 4; i++) begin
				cx_q[i] <= coef(i, win[0].x, win[1].x, win[2].x, win[3].x);
				cy_q[i] <= coef(i, win[0].y, win[1].y, win[2].y, win[3].y);
			end
	end

	// vertex pipeline: weights, products, sum, then divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			v1_q <= cmd.vtx_start;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.vtx_start) begin
			w_s1[0] <= WW'(j3);
			w_s1[1] <= WW'(14'd3 * WW'(j2) * WW'(n_eff));
			w_s1[2] <= WW'(14'd3 * WW'(cmd.j) * WW'(n2));
			w_s1[3] <= WW'(n3);
		end
		if (v1_q)
			for (int i = 0; i < 4; i++) begin
				px_s2[i] <= prod_t'(cx_q[i]) * prod_t'($signed({1'b0, w_s1[i]}));
				py_s2[i] <= prod_t'(cy_q[i]) * prod_t'($signed({1'b0, w_s1[i]}));
			end
		if (v2_q) begin
			nx_s3 <= NW'(px_s2[0] + px_s2[1] + px_s2[2] + px_s2[3]);
			ny_s3 <= NW'(py_s2[0] + py_s2[1] + py_s2[2] + py_s2[3]);
		end
	end

	bsc_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(v3_q), .clear(cmd.push),
		.num(nx_s3), .den(den), .done(done_x), .quo(qx)
	);

	bsc_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(v3_q), .clear(cmd.push),
		.num(ny_s3), .den(den), .done(done_y), .quo(qy)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.push)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push)
			out_q <= '{curve_x: qx, curve_y: qy, pen_move: cmd.move,
			           last_vertex: cmd.last};
	end

	assign out_valid     = out_valid_q;
	assign out_word      = out_q;
	assign sts.res_ready = done_x & done_y;
	assign sts.out_free  = !out_valid_q || !out_stall;
	assign sts.n_eff     = n_eff;

endmodule

// ===== hdl/bsc_ctrl.sv =====
// Controller: point count, segment sequencing and vertex stepping.
// Depends on bsc_pkg; drives the datapath through cmd_t, reads sts_t.
module bsc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_stall,
	output bsc_pkg::cmd_t cmd,
	input  bsc_pkg::sts_t sts
);
	import bsc_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_NEXT = 2'd1;
	localparam logic [1:0] S_VTX  = 2'd2;
	localparam logic [1:0] S_WAIT = 2'd3;

	logic [1:0] state_q;
	logic [2:0] seen_q;
	logic       main_q, shifted_q, fresh_q, move_q, final_q;
	logic [1:0] close_left_q, close_k_q, mode_q;
	step_t      j_q;
	logic       take, push, start_seg;
	logic [3:0] total;

	assign take      = (state_q == S_IDLE) && in_valid;
	assign total     = {1'b0, seen_q} + 4'd1;
	assign push      = (state_q == S_WAIT) && sts.res_ready && sts.out_free;
	assign start_seg = (state_q == S_NEXT) &&
	                   (main_q || (shifted_q && close_left_q != '0));
	assign in_stall  = state_q != S_IDLE;

	always_comb begin
		cmd           = '0;
		cmd.in_take   = take;
		cmd.op_wr     = take && seen_q < 3'd3;
		cmd.op_idx    = seen_q[1:0];
		cmd.seg_load  = start_seg;
		cmd.sel       = main_q ? SEL_MAIN : mode_q;
		cmd.seg_k     = main_q ? 2'd0 : close_k_q;
		cmd.shift     = (state_q == S_NEXT) && !main_q && !shifted_q;
		cmd.vtx_start = state_q == S_VTX;
		cmd.j         = j_q;
		cmd.push      = push;
		cmd.move      = move_q;
		cmd.last      = final_q && !move_q && j_q == sts.n_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			seen_q       <= '0;
			main_q       <= 1'b0;
			shifted_q    <= 1'b0;
			fresh_q      <= 1'b0;
			move_q       <= 1'b0;
			final_q      <= 1'b0;
			close_left_q <= '0;
			close_k_q    <= '0;
			mode_q       <= SEL_THREE;
			j_q          <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						main_q    <= seen_q >= 3'd3;
						fresh_q   <= seen_q <= 3'd3;
						shifted_q <= 1'b0;
						close_k_q <= '0;
						mode_q    <= (total == 4'd2) ? SEL_TWO : SEL_THREE;
						if (in_last) begin
							close_left_q <= (total == 4'd2) ? 2'd2 :
							                (total >= 4'd3) ? 2'd3 : 2'd0;
							seen_q <= '0;
						end else begin
							close_left_q <= '0;
							if (seen_q != 3'd7)
								seen_q <= seen_q + 3'd1;
						end
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (start_seg) begin
						if (main_q) begin
							main_q  <= 1'b0;
							final_q <= 1'b0;
						end else begin
							close_k_q    <= close_k_q + 2'd1;
							close_left_q <= close_left_q - 2'd1;
							final_q      <= close_left_q == 2'd1;
						end
						// first segment of a polygon opens with a move at t=0
						move_q  <= fresh_q;
						j_q     <= fresh_q ? step_t'(0) : step_t'(1);
						fresh_q <= 1'b0;
						state_q <= S_VTX;
					end else if (!shifted_q) begin
						shifted_q <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_VTX: state_q <= S_WAIT;
				S_WAIT: begin
					if (push) begin
						if (move_q) begin
							move_q  <= 1'b0;
							state_q <= S_VTX;
						end else if (j_q == sts.n_eff) begin
							state_q <= S_NEXT;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_VTX;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_push_ok: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (sts.res_ready && sts.out_free))
		else $error("vertex pushed without result or free output");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == S_NEXT))
		else $error("accepted word did not start sequencing");
	a_j_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT) |-> (j_q <= sts.n_eff))
		else $error("vertex index beyond step count");
	a_move_t0: assert property (@(posedge clk) disable iff (!arst_n)
		(push && move_q) |-> (j_q == '0 && !cmd.last))
		else $error("move vertex away from t=0");
`endif

endmodule

// ===== hdl/closed_bspline_curve_points_top.sv =====
// Top level of the closed uniform cubic B-spline curve generator.
// Depends on bsc_pkg, bsc_ctrl, bsc_dp (which holds two bsc_div units).
//
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_stall   | in_word_t  (point_x, point_y, is_last_point)
//  out     | output    | out_valid / out_stall | out_word_t (curve_x, curve_y, pen_move, last_vertex)
//  cfg     | input     | cfg_we                | steps_per_segment (4 bits)
//
// One input word at a time. Each vertex is issued, then passes the weight,
// product and sum registers and the divider, which produces one quotient bit
// per cycle, then is pushed. A word yields N vertices per segment, N the step
// count; the opening segment adds its move and its t=0 draw vertex.
// Reset clears the controller, count and step register (8); point stores
// are undefined until written. A stalled output holds the next vertex in
// the divider; the input stays stalled until all vertices of a word are pushed.
module closed_bspline_curve_points_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  bsc_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output bsc_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  bsc_pkg::step_t     cfg_wdata
);
	import bsc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing of segments and vertices
	bsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_word.is_last_point),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// point stores, evaluation and output word register
	bsc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
